@@ design/particulate_frame_deframer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the particulate frame deframer
// Shared helpers for concurrent checks, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARTICULATE_FRAME_DEFRAMER_MACROS_SVH
`define PARTICULATE_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define PFD_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define PFD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ design/pfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pfd_pkg
// Constants and types shared by the particulate frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

  localparam int FRAME_LEN = 10;
  // the last byte of a frame is never stored; it is the byte in transfer
  localparam int NUM_CELLS = FRAME_LEN - 1;
  localparam int COUNT_W   = $clog2(FRAME_LEN);

  localparam logic [7:0] HEADER_BYTE  = 8'hAA;
  localparam logic [7:0] TRAILER_BYTE = 8'hAB;

  typedef struct packed {
    logic [15:0] pm25_tenths;
    logic [15:0] pm10_tenths;
    logic        pm25_changed;
    logic        pm10_changed;
  } pfd_result_t;

endpackage

`default_nettype wire

@@ design/particulate_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// particulate_frame_deframer
// Ten-byte particulate sensor frame parser with checksum and change flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel rx_valid/rx_stall/rx_byte carries one received serial byte
//   per transfer. Output channel out_valid/out_stall carries one reading
//   (pm25_tenths, pm10_tenths and their changed flags) for every ten-byte
//   frame with header 0xAA, trailer 0xAB and a matching sum checksum.
//   Throughput: one byte per cycle while not stalled, set by the nine-cell
//   byte shift line, which moves one step per accepted byte; a failed
//   trailer realigns the window in the same cycle by a priority pick over
//   the cell header flags. Readings are registered in the output stage.
//   A two-entry output stage lets bytes keep flowing while one reading waits;
//   rx_stall rises only once a second reading is held behind a stalled
//   receiver, and falls as soon as the receiver takes one.
//   Reset (rst, synchronous) empties the window, clears the stored last
//   readings to zero and drops any pending output. No clearing pass is
//   needed; the cells hold data only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particulate_frame_deframer_macros.svh"

module particulate_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pm25_tenths,
  output logic [15:0] pm10_tenths,
  output logic        pm25_changed,
  output logic        pm10_changed
);
  import pfd_pkg::*;

  localparam logic [COUNT_W-1:0] LAST_CNT = COUNT_W'(NUM_CELLS);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] realign_cnt;
  logic [15:0]        last_pm25;
  logic [15:0]        last_pm10;

  logic [7:0]           cell_q [NUM_CELLS];
  logic [NUM_CELLS-1:0] cell_hdr;

  logic        acc;
  logic        append;
  logic        full;
  logic        trailer_ok;
  logic [7:0]  sum;
  logic        res_valid;
  pfd_result_t res;
  pfd_result_t out_res;
  logic        buf_full;

  assign acc    = rx_valid && !rx_stall;
  assign append = (count != '0) || (rx_byte == HEADER_BYTE);
  assign full   = append && (count == LAST_CNT);

  // cell 0 holds the newest byte
  genvar k;
  generate
    for (k = 0; k < NUM_CELLS; k++) begin : g_cell
      pfd_cell u_cell (
        .clk      (clk),
        .shift    (acc && append),
        .din      ((k == 0) ? rx_byte : cell_q[(k == 0) ? 0 : k - 1]),
        .dout     (cell_q[k]),
        .is_header(cell_hdr[k])
      );
    end
  endgenerate

  // With nine bytes held plus the incoming one, frame byte j sits in cell 8-j
  // and byte 9 is rx_byte.
  assign trailer_ok = (rx_byte == TRAILER_BYTE);
  assign sum = cell_q[1] + cell_q[2] + cell_q[3] + cell_q[4] + cell_q[5] + cell_q[6];

  assign res.pm25_tenths  = {cell_q[5], cell_q[6]};
  assign res.pm10_tenths  = {cell_q[3], cell_q[4]};
  assign res.pm25_changed = (res.pm25_tenths != last_pm25);
  assign res.pm10_changed = (res.pm10_tenths != last_pm10);
  assign res_valid        = acc && full && trailer_ok && (sum == cell_q[0]);

  // Realign: the earliest header after frame byte 0 becomes the new start.
  // Cell c holds frame byte 8-c, so the oldest matching cell wins.
  always_comb begin
    realign_cnt = (rx_byte == HEADER_BYTE) ? COUNT_W'(1) : '0;
    for (int c = 0; c < NUM_CELLS - 1; c++) begin
      if (cell_hdr[c]) begin
        realign_cnt = COUNT_W'(c + 2);
      end
    end
  end

  always_comb begin
    count_next = count;
    if (acc && append) begin
      if (!full) begin
        count_next = count + COUNT_W'(1);
      end else if (trailer_ok) begin
        count_next = '0;
      end else begin
        count_next = realign_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      last_pm25 <= '0;
      last_pm10 <= '0;
    end else begin
      count <= count_next;
      if (res_valid) begin
        last_pm25 <= res.pm25_tenths;
        last_pm10 <= res.pm10_tenths;
      end
    end
  end

  pfd_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign rx_stall     = buf_full;
  assign pm25_tenths  = out_res.pm25_tenths;
  assign pm10_tenths  = out_res.pm10_tenths;
  assign pm25_changed = out_res.pm25_changed;
  assign pm10_changed = out_res.pm10_changed;

  `PFD_ASSERT_NOW(a_count_range, 1'b1, count <= LAST_CNT, "window count out of range")
  `PFD_ASSERT_NOW(a_stall_needs_out, rx_stall, out_valid, "input stalled with empty output")
  `PFD_ASSERT_NEXT(a_frame_clears, acc && full && trailer_ok, count == '0,
                   "window not emptied after framed packet")
  `PFD_ASSERT_NEXT(a_result_shown, res_valid && !out_valid, out_valid,
                   "accepted reading not presented")

endmodule

`default_nettype wire

@@ design/pfd_cell.sv @@
// ----------------------------------------------------------------------------
// pfd_cell
// One byte of the receive shift line, with a local header match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  output logic [7:0] dout,
  output logic       is_header
);
  import pfd_pkg::*;

  logic [7:0] data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= din;
    end
  end

  assign dout      = data;
  assign is_header = (data == HEADER_BYTE);

endmodule

`default_nettype wire

@@ design/pfd_outbuf.sv @@
// ----------------------------------------------------------------------------
// pfd_outbuf
// Two-entry output stage: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  pfd_pkg::pfd_result_t res,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output pfd_pkg::pfd_result_t out_res
);
  import pfd_pkg::*;

  logic        skid_valid;
  pfd_result_t skid;
  logic        take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // upstream is stalled while the skid entry is occupied
      if (take) begin
        out_res    <= skid;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || take) begin
      out_valid <= res_valid;
      out_res   <= res;
    end else if (res_valid) begin
      skid       <= res;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire
